@@ src/cssu_pkg.sv @@
package cssu_pkg;

  // Arrow bitmap size; bits outside it are transparent
  localparam int unsigned ARROW_ROWS = 12;
  localparam int unsigned ARROW_COLS = 8;

  // Field widths fixed by the stream format
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned ROW_W    = 4;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned COLOUR_W = 32;
  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned SCREEN_W = 13;
  localparam int unsigned STRIDE_W = 15;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 88;

  // Action codes
  localparam logic ACT_SHOW = 1'b0;
  localparam logic ACT_HIDE = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_LINE_STRIDE   = 3'd2,
    CFG_BYTES_PER_PIX = 3'd3,
    CFG_OUTLINE       = 3'd4,
    CFG_FILL          = 3'd5
  } cfg_idx_t;

  // Three-byte pixel size code
  localparam logic [BPP_W-1:0] BPP_THREE = 3'd3;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [STRIDE_W-1:0] line_stride;
    logic [BPP_W-1:0]    bytes_per_pixel;
    logic [COLOUR_W-1:0] outline_colour;
    logic [COLOUR_W-1:0] fill_colour;
  } cfg_t;

  typedef struct packed {
    logic                action;
    logic [COORD_W-1:0]  cursor_x;
    logic [COORD_W-1:0]  cursor_y;
    logic [ROW_W-1:0]    box_row;
    logic [COL_W-1:0]    box_col;
    logic [COLOUR_W-1:0] screen_pixel;
    logic                last_pixel;
  } item_t;

  typedef struct packed {
    logic                write_enable;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOUR_W-1:0] write_colour;
  } res_t;

  // Outline mask, MSB is the leftmost column
  function automatic logic [ARROW_COLS-1:0] arrow_black(input logic [ROW_W-1:0] row);
    logic [ARROW_COLS-1:0] m;
    case (row)
      4'd0:    m = 8'h80;
      4'd1:    m = 8'hC0;
      4'd2:    m = 8'hA0;
      4'd3:    m = 8'h90;
      4'd4:    m = 8'h88;
      4'd5:    m = 8'h84;
      4'd6:    m = 8'h82;
      4'd7:    m = 8'h9E;
      4'd8:    m = 8'hD0;
      4'd9:    m = 8'h68;
      4'd10:   m = 8'h14;
      4'd11:   m = 8'h08;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Fill mask, MSB is the leftmost column
  function automatic logic [ARROW_COLS-1:0] arrow_white(input logic [ROW_W-1:0] row);
    logic [ARROW_COLS-1:0] m;
    case (row)
      4'd2:    m = 8'h40;
      4'd3:    m = 8'h60;
      4'd4:    m = 8'h70;
      4'd5:    m = 8'h78;
      4'd6:    m = 8'h7C;
      4'd7:    m = 8'h60;
      4'd8:    m = 8'h20;
      4'd9:    m = 8'h10;
      4'd10:   m = 8'h08;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Drop the top byte for three-byte pixels
  function automatic logic [COLOUR_W-1:0] size_colour(input logic [COLOUR_W-1:0] c,
                                                      input logic [BPP_W-1:0] bpp);
    return (bpp == BPP_THREE) ? {8'h00, c[23:0]} : c;
  endfunction

endpackage

@@ src/cursor_sprite_save_under_core.sv @@
// Cursor overlay with save-under. Each input beat is one pixel of the cursor box:
// a show beat (tuser 0) latches the box position, saves the framebuffer colour
// under the pixel and draws the arrow outline or fill; a hide beat (tuser 1)
// restores the saved colour. Every input beat yields one output beat with the
// write enable, screen coordinates, byte offset and colour. Throughput is one
// pixel per clock while out_tready does not stall the output; each beat passes
// an input stage that also reads the save-under RAM and then the result register.
// tlast on a show pass marks the save valid, on a hide pass clears it.
// Write configuration only while no pixel is in flight.
module cursor_sprite_save_under_core #(
  parameter int unsigned BOX_WIDTH  = 8,
  parameter int unsigned BOX_HEIGHT = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: cursor_x[11:0], cursor_y[23:12], box_row[27:24], box_col[30:28],
  //           screen_pixel[62:31], zero[63]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cssu_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: action[0]
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  // out_tdata: write_enable[0], pixel_x[12:1], pixel_y[24:13],
  //            byte_offset[50:25], write_colour[82:51], zero[87:83]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cssu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [cssu_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [cssu_pkg::CFG_DW-1:0]         cfg_wdata
);

  localparam int unsigned SAVE_DEPTH = BOX_WIDTH * BOX_HEIGHT;
  localparam int unsigned AW         = $clog2(SAVE_DEPTH);

  cssu_pkg::cfg_t                cfg_r;
  cssu_pkg::item_t               in_item;
  cssu_pkg::item_t               stg_r;
  logic                          stg_valid_r;
  logic [cssu_pkg::COORD_W-1:0]  box_left_r;
  logic [cssu_pkg::COORD_W-1:0]  box_top_r;
  logic                          save_valid_r;
  logic                          fwd_hit_r;
  logic [cssu_pkg::COLOUR_W-1:0] fwd_data_r;
  cssu_pkg::res_t                out_r;
  logic                          out_valid_r;

  logic                          in_acc;
  logic                          stg_adv;
  logic [AW-1:0]                 rd_addr;
  logic [cssu_pkg::COLOUR_W-1:0] rd_data;
  logic [cssu_pkg::COLOUR_W-1:0] saved_word;
  cssu_pkg::res_t                calc_res;
  logic                          save_wr;
  logic [AW-1:0]                 save_addr;
  logic [cssu_pkg::COLOUR_W-1:0] save_data;

  // Unpack the input beat
  assign in_item.action       = in_tuser;
  assign in_item.cursor_x     = in_tdata[11:0];
  assign in_item.cursor_y     = in_tdata[23:12];
  assign in_item.box_row      = in_tdata[27:24];
  assign in_item.box_col      = in_tdata[30:28];
  assign in_item.screen_pixel = in_tdata[62:31];
  assign in_item.last_pixel   = in_tlast;

  // Handshake: stage moves when the result register is free or draining
  assign stg_adv   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || stg_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= 13'd640;
      cfg_r.screen_height   <= 13'd480;
      cfg_r.line_stride     <= 15'd2560;
      cfg_r.bytes_per_pixel <= 3'd4;
      cfg_r.outline_colour  <= 32'h0000_0000;
      cfg_r.fill_colour     <= 32'h00FF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cssu_pkg::CFG_SCREEN_WIDTH:  cfg_r.screen_width    <= cfg_wdata[12:0];
        cssu_pkg::CFG_SCREEN_HEIGHT: cfg_r.screen_height   <= cfg_wdata[12:0];
        cssu_pkg::CFG_LINE_STRIDE:   cfg_r.line_stride     <= cfg_wdata[14:0];
        cssu_pkg::CFG_BYTES_PER_PIX: cfg_r.bytes_per_pixel <= cfg_wdata[2:0];
        cssu_pkg::CFG_OUTLINE:       cfg_r.outline_colour  <= cfg_wdata;
        cssu_pkg::CFG_FILL:          cfg_r.fill_colour     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Save-under RAM, read as the beat is taken
  assign rd_addr = AW'(32'(in_item.box_row) * BOX_WIDTH + 32'(in_item.box_col));

  cssu_save_ram #(
    .DEPTH (SAVE_DEPTH),
    .AW    (AW)
  ) u_save_ram (
    .clk     (clk),
    .wr_en   (stg_adv && save_wr),
    .wr_addr (save_addr),
    .wr_data (save_data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Forward a save that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_hit_r  <= stg_adv && save_wr && (save_addr == rd_addr);
      fwd_data_r <= save_data;
    end
  end

  assign saved_word = fwd_hit_r ? fwd_data_r : rd_data;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_acc) begin
      stg_valid_r <= 1'b1;
    end else if (stg_adv) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_r <= in_item;
    end
  end

  cssu_pixel_calc #(
    .BOX_WIDTH  (BOX_WIDTH),
    .BOX_HEIGHT (BOX_HEIGHT),
    .AW         (AW)
  ) u_pixel_calc (
    .item       (stg_r),
    .cfg        (cfg_r),
    .box_left   (box_left_r),
    .box_top    (box_top_r),
    .save_valid (save_valid_r),
    .saved_word (saved_word),
    .res        (calc_res),
    .save_wr    (save_wr),
    .save_addr  (save_addr),
    .save_data  (save_data)
  );

  // Box position and save state advance with each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r   <= '0;
      box_top_r    <= '0;
      save_valid_r <= 1'b0;
    end else if (stg_adv) begin
      if (stg_r.action == cssu_pkg::ACT_SHOW) begin
        box_left_r <= stg_r.cursor_x;
        box_top_r  <= stg_r.cursor_y;
      end
      if (stg_r.last_pixel) begin
        save_valid_r <= (stg_r.action == cssu_pkg::ACT_SHOW);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      out_r <= calc_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.write_colour, out_r.byte_offset, out_r.pixel_y,
                       out_r.pixel_x, out_r.write_enable};

endmodule

@@ src/cssu_save_ram.sv @@
module cssu_save_ram #(
  parameter int unsigned DEPTH = 96,
  parameter int unsigned AW    = 7
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [cssu_pkg::COLOUR_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [cssu_pkg::COLOUR_W-1:0] rd_data
);

  logic [cssu_pkg::COLOUR_W-1:0] mem [DEPTH];
  logic [cssu_pkg::COLOUR_W-1:0] rd_data_r;

  // Save-under store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/cssu_pixel_calc.sv @@
module cssu_pixel_calc #(
  parameter int unsigned BOX_WIDTH  = 8,
  parameter int unsigned BOX_HEIGHT = 12,
  parameter int unsigned AW         = 7
) (
  input  cssu_pkg::item_t               item,
  input  cssu_pkg::cfg_t                cfg,
  input  logic [cssu_pkg::COORD_W-1:0]  box_left,
  input  logic [cssu_pkg::COORD_W-1:0]  box_top,
  input  logic                          save_valid,
  input  logic [cssu_pkg::COLOUR_W-1:0] saved_word,
  output cssu_pkg::res_t                res,
  output logic                          save_wr,
  output logic [AW-1:0]                 save_addr,
  output logic [cssu_pkg::COLOUR_W-1:0] save_data
);

  localparam int unsigned PROD_W = 28;

  logic [cssu_pkg::COORD_W-1:0]    left;
  logic [cssu_pkg::COORD_W-1:0]    top;
  logic [cssu_pkg::SCREEN_W-1:0]   sx;
  logic [cssu_pkg::SCREEN_W-1:0]   sy;
  logic                            on_screen;
  logic                            in_box;
  logic                            is_show;
  logic [cssu_pkg::ARROW_COLS-1:0] black_row;
  logic [cssu_pkg::ARROW_COLS-1:0] white_row;
  logic                            black_bit;
  logic                            white_bit;
  logic                            we;
  logic [cssu_pkg::COLOUR_W-1:0]   colour;
  logic [PROD_W-1:0]               row_bytes;
  logic [PROD_W-1:0]               col_bytes;
  logic [PROD_W-1:0]               offset_full;

  // A show takes its own position, a hide the latched one
  assign is_show = (item.action == cssu_pkg::ACT_SHOW);
  assign left    = is_show ? item.cursor_x : box_left;
  assign top     = is_show ? item.cursor_y : box_top;

  // Screen coordinates without wrap, and clipping
  assign sx        = {1'b0, left} + {{(cssu_pkg::SCREEN_W-cssu_pkg::COL_W){1'b0}}, item.box_col};
  assign sy        = {1'b0, top} + {{(cssu_pkg::SCREEN_W-cssu_pkg::ROW_W){1'b0}}, item.box_row};
  assign on_screen = (sx < cfg.screen_width) && (sy < cfg.screen_height);
  assign in_box    = (32'(item.box_row) < BOX_HEIGHT) && (32'(item.box_col) < BOX_WIDTH);
  assign save_addr = AW'(32'(item.box_row) * BOX_WIDTH + 32'(item.box_col));

  // Mask bits; the arrow tables read as zero outside the bitmap
  assign black_row = cssu_pkg::arrow_black(item.box_row);
  assign white_row = cssu_pkg::arrow_white(item.box_row);
  assign black_bit = black_row[~item.box_col];
  assign white_bit = white_row[~item.box_col];

  // Save the colour under a show pixel, zero when clipped
  assign save_wr   = is_show && in_box;
  assign save_data = on_screen ? cssu_pkg::size_colour(item.screen_pixel, cfg.bytes_per_pixel)
                               : '0;

  // Pick draw or restore colour
  always_comb begin
    we     = 1'b0;
    colour = '0;
    if (is_show) begin
      if (in_box && on_screen) begin
        if (black_bit) begin
          we     = 1'b1;
          colour = cssu_pkg::size_colour(cfg.outline_colour, cfg.bytes_per_pixel);
        end else if (white_bit) begin
          we     = 1'b1;
          colour = cssu_pkg::size_colour(cfg.fill_colour, cfg.bytes_per_pixel);
        end
      end
    end else if (save_valid && in_box && on_screen) begin
      we     = 1'b1;
      colour = cssu_pkg::size_colour(saved_word, cfg.bytes_per_pixel);
    end
  end

  // Byte offset: row times stride plus column times pixel size
  assign row_bytes   = PROD_W'(sy) * PROD_W'(cfg.line_stride);
  assign col_bytes   = PROD_W'(sx) * PROD_W'(cfg.bytes_per_pixel);
  assign offset_full = row_bytes + col_bytes;

  assign res.write_enable = we;
  assign res.pixel_x      = sx[cssu_pkg::COORD_W-1:0];
  assign res.pixel_y      = sy[cssu_pkg::COORD_W-1:0];
  assign res.byte_offset  = offset_full[cssu_pkg::OFFSET_W-1:0];
  assign res.write_colour = colour;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SAVE_DEPTH  = 96;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 400;

  // Arrow masks, row 0 first, MSB is the leftmost column
  localparam logic [0:11][7:0] OUTLINE_ROWS = {
    8'h80, 8'hC0, 8'hA0, 8'h90, 8'h88, 8'h84,
    8'h82, 8'h9E, 8'hD0, 8'h68, 8'h14, 8'h08
  };
  localparam logic [0:11][7:0] FILL_ROWS = {
    8'h00, 8'h00, 8'h40, 8'h60, 8'h70, 8'h78,
    8'h7C, 8'h60, 8'h20, 8'h10, 8'h08, 8'h00
  };

  logic                             clk;
  logic                             rst_n     = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [cssu_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                             in_tuser  = 1'b0;
  logic                             in_tlast  = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [cssu_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_we    = 1'b0;
  logic [cssu_pkg::CFG_AW-1:0]      cfg_addr  = '0;
  logic [cssu_pkg::CFG_DW-1:0]      cfg_wdata = '0;

  cursor_sprite_save_under_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Register shadow, reset values
  logic [cssu_pkg::SCREEN_W-1:0] scr_width  = 13'd640;
  logic [cssu_pkg::SCREEN_W-1:0] scr_height = 13'd480;
  logic [cssu_pkg::STRIDE_W-1:0] stride     = 15'd2560;
  logic [cssu_pkg::BPP_W-1:0]    bpp        = 3'd4;
  logic [cssu_pkg::COLOUR_W-1:0] outline    = 32'h0;
  logic [cssu_pkg::COLOUR_W-1:0] fill       = 32'h00FF_FFFF;

  // Overlay state as the block should hold it
  logic [cssu_pkg::COLOUR_W-1:0] saved_colour [SAVE_DEPTH];
  logic [cssu_pkg::COORD_W-1:0]  box_left   = '0;
  logic [cssu_pkg::COORD_W-1:0]  box_top    = '0;
  logic                          save_valid = 1'b0;

  // Stimulus-side tracking that keeps hides away from never-saved entries
  bit gen_written [SAVE_DEPTH];
  bit gen_valid    = 1'b0;
  int pushed_total = 0;

  cssu_pkg::item_t pixels_to_send [$];
  cssu_pkg::res_t  expected_writes [$];
  cssu_pkg::item_t in_item;

  bit steady     = 1'b0;
  int mismatches = 0;
  int outs_seen  = 0;
  int in_gap     = 0;
  int out_gap    = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [cssu_pkg::COLOUR_W-1:0] trim_colour(
      input logic [cssu_pkg::COLOUR_W-1:0] c);
    return (bpp == cssu_pkg::BPP_THREE) ? {8'h00, c[23:0]} : c;
  endfunction

  // Work out the output beat of one accepted pixel and advance the state
  function automatic cssu_pkg::res_t cursor_pixel_result(input cssu_pkg::item_t it);
    cssu_pkg::res_t r;
    logic [cssu_pkg::SCREEN_W-1:0] sx, sy;
    logic [31:0] full_offset;
    logic on_screen, in_box, we;
    logic [cssu_pkg::COLOUR_W-1:0] colour;
    int idx;
    if (it.action == cssu_pkg::ACT_SHOW) begin
      box_left = it.cursor_x;
      box_top  = it.cursor_y;
    end
    sx = {1'b0, box_left} + 13'(it.box_col);
    sy = {1'b0, box_top} + 13'(it.box_row);
    on_screen = (sx < scr_width) && (sy < scr_height);
    in_box = it.box_row < 4'd12;
    idx = int'(it.box_row) * 8 + int'(it.box_col);
    we = 1'b0;
    colour = '0;
    if (it.action == cssu_pkg::ACT_SHOW) begin
      if (in_box) begin
        saved_colour[idx] = on_screen ? trim_colour(it.screen_pixel) : '0;
        if (on_screen && OUTLINE_ROWS[it.box_row][7 - it.box_col]) begin
          we = 1'b1;
          colour = trim_colour(outline);
        end else if (on_screen && FILL_ROWS[it.box_row][7 - it.box_col]) begin
          we = 1'b1;
          colour = trim_colour(fill);
        end
      end
      if (it.last_pixel) save_valid = 1'b1;
    end else begin
      if (save_valid && in_box && on_screen) begin
        we = 1'b1;
        colour = trim_colour(saved_colour[idx]);
      end
      if (it.last_pixel) save_valid = 1'b0;
    end
    full_offset = 32'(sy) * 32'(stride) + 32'(sx) * 32'(bpp);
    r.write_enable = we;
    r.pixel_x      = sx[cssu_pkg::COORD_W-1:0];
    r.pixel_y      = sy[cssu_pkg::COORD_W-1:0];
    r.byte_offset  = full_offset[cssu_pkg::OFFSET_W-1:0];
    r.write_colour = we ? colour : '0;
    return r;
  endfunction

  // Queue one pixel; a hide that would read a never-saved entry becomes a show
  task automatic push_pixel(input logic act, input logic [11:0] x, input logic [11:0] y,
                            input logic [3:0] row, input logic [2:0] col,
                            input logic [31:0] pix, input logic last);
    cssu_pkg::item_t it;
    int idx;
    idx = int'(row) * 8 + int'(col);
    if (act == cssu_pkg::ACT_HIDE && gen_valid && row < 4'd12 && !gen_written[idx])
      act = cssu_pkg::ACT_SHOW;
    if (act == cssu_pkg::ACT_SHOW && row < 4'd12) gen_written[idx] = 1'b1;
    if (last) gen_valid = (act == cssu_pkg::ACT_SHOW);
    it.action       = act;
    it.cursor_x     = x;
    it.cursor_y     = y;
    it.box_row      = row;
    it.box_col      = col;
    it.screen_pixel = pix;
    it.last_pixel   = last;
    pixels_to_send.push_back(it);
    pushed_total++;
  endtask

  task automatic write_reg(input cssu_pkg::cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      cssu_pkg::CFG_SCREEN_WIDTH:  scr_width  = val[cssu_pkg::SCREEN_W-1:0];
      cssu_pkg::CFG_SCREEN_HEIGHT: scr_height = val[cssu_pkg::SCREEN_W-1:0];
      cssu_pkg::CFG_LINE_STRIDE:   stride     = val[cssu_pkg::STRIDE_W-1:0];
      cssu_pkg::CFG_BYTES_PER_PIX: bpp        = val[cssu_pkg::BPP_W-1:0];
      cssu_pkg::CFG_OUTLINE:       outline    = val;
      cssu_pkg::CFG_FILL:          fill       = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] s, input logic [31:0] b,
                              input logic [31:0] oc, input logic [31:0] fc);
    write_reg(cssu_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(cssu_pkg::CFG_SCREEN_HEIGHT, h);
    write_reg(cssu_pkg::CFG_LINE_STRIDE, s);
    write_reg(cssu_pkg::CFG_BYTES_PER_PIX, b);
    write_reg(cssu_pkg::CFG_OUTLINE, oc);
    write_reg(cssu_pkg::CFG_FILL, fc);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every pixel is sent and every write has come back
  task automatic wait_idle();
    while (pixels_to_send.size() != 0 || in_tvalid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Box origin, biased toward the clipping edge and the corners
  function automatic logic [11:0] pick_coord(input int limit);
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 4095);
      1:       v = limit - int'($urandom_range(0, 14));
      2:       v = $urandom_range(0, 15);
      default: v = (limit > 1) ? int'($urandom_range(0, limit - 1)) : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Mostly show passes followed by hide passes over the same cells, plus noise
  task automatic random_phase(input int n);
    logic [3:0] rows [16];
    logic [2:0] cols [16];
    logic [11:0] cx, cy;
    int start, k, i;
    bit broken;
    start = pushed_total;
    while (pushed_total - start < n) begin
      if ($urandom_range(0, 9) < 7) begin
        cx = pick_coord(int'(scr_width));
        cy = pick_coord(int'(scr_height));
        k = $urandom_range(1, 12);
        broken = ($urandom_range(0, 7) == 0);
        for (i = 0; i < k; i++) begin
          rows[i] = broken ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 11));
          cols[i] = 3'($urandom_range(0, 7));
          push_pixel(cssu_pkg::ACT_SHOW, cx, cy, rows[i], cols[i], $urandom,
                     (i == k - 1) && !(broken && $urandom_range(0, 1) == 0));
        end
        if ($urandom_range(0, 4) != 0) begin
          broken = ($urandom_range(0, 7) == 0);
          for (i = k - 1; i >= 0; i--)
            push_pixel(cssu_pkg::ACT_HIDE, 12'($urandom), 12'($urandom), rows[i], cols[i],
                       $urandom, (i == 0) && !broken);
        end
      end else begin
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++)
          push_pixel(1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
                     4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), $urandom,
                     $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Sender: hold each beat until taken, idle in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_writes.push_back(cursor_pixel_result(in_item));
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pixels_to_send.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!steady && $urandom_range(0, 7) == 0) begin
          in_gap    <= $urandom_range(0, 8);
          in_tvalid <= 1'b0;
        end else begin
          in_item = pixels_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, in_item.screen_pixel, in_item.box_col, in_item.box_row,
                        in_item.cursor_y, in_item.cursor_x};
          in_tuser  <= in_item.action;
          in_tlast  <= in_item.last_pixel;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver: check each write beat, stall in bursts and once for a long stretch
  always @(posedge clk) begin
    cssu_pkg::res_t want;
    cssu_pkg::res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        outs_seen++;
        got.write_enable = out_tdata[0];
        got.pixel_x      = out_tdata[12:1];
        got.pixel_y      = out_tdata[24:13];
        got.byte_offset  = out_tdata[50:25];
        got.write_colour = out_tdata[82:51];
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %0h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
          check_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
          check_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
          check_field("write_colour", want.write_colour, got.write_colour);
        end
      end
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && outs_seen >= 100 && pixels_to_send.size() > 30) begin
        hold_done  <= 1'b1;
        hold_left  <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_gap    <= $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat or register write moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** cursor_sprite_save_under_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Hide with nothing saved
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd0, 3'd0, 32'h0, 1'b1);
    // Show pass: outline, fill, transparent column, rows outside the box
    push_pixel(cssu_pkg::ACT_SHOW, 12'd10, 12'd20, 4'd0, 3'd0, 32'hFFFF_FFFF, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd10, 12'd20, 4'd2, 3'd1, 32'h0, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd10, 12'd20, 4'd0, 3'd7, 32'h1234_5678, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd10, 12'd20, 4'd11, 3'd7, 32'h8765_4321, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd10, 12'd20, 4'd13, 3'd3, 32'hDEAD_BEEF, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd10, 12'd20, 4'd15, 3'd7, 32'hCAFE_F00D, 1'b1);
    // Hide pass restores, then a hide after the pass closed
    push_pixel(cssu_pkg::ACT_HIDE, 12'hFFF, 12'hFFF, 4'd0, 3'd0, 32'h0, 1'b0);
    push_pixel(cssu_pkg::ACT_HIDE, 12'hFFF, 12'hFFF, 4'd2, 3'd1, 32'h0, 1'b0);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd0, 3'd7, 32'h0, 1'b0);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd12, 3'd0, 32'h0, 1'b0);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd11, 3'd7, 32'h0, 1'b1);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd0, 3'd0, 32'h0, 1'b0);
    // Box at the far corner: coordinates run past 12 bits, all off screen
    push_pixel(cssu_pkg::ACT_SHOW, 12'hFFF, 12'hFFF, 4'd0, 3'd7, 32'hFFFF_FFFF, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'hFFF, 12'hFFF, 4'd11, 3'd0, 32'hFFFF_FFFF, 1'b1);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd0, 3'd7, 32'h0, 1'b0);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd11, 3'd0, 32'h0, 1'b1);
    // Clip right at the last visible column and row
    push_pixel(cssu_pkg::ACT_SHOW, 12'd636, 12'd479, 4'd0, 3'd3, 32'h00AB_CDEF, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd636, 12'd479, 4'd0, 3'd4, 32'h00AB_CDEF, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd636, 12'd479, 4'd1, 3'd0, 32'h00AB_CDEF, 1'b1);
    wait_idle();

    // Three-byte pixels trim saved and drawn colours
    program_regs(16, 16, 48, 3, 32'hAABB_CCDD, 32'h1122_3344);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd0, 12'd0, 4'd2, 3'd0, 32'hFFFF_FFFF, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd0, 12'd0, 4'd2, 3'd1, 32'hFFFF_FFFF, 1'b0);
    push_pixel(cssu_pkg::ACT_SHOW, 12'd0, 12'd0, 4'd3, 3'd1, 32'h8000_0001, 1'b1);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd2, 3'd0, 32'h0, 1'b0);
    push_pixel(cssu_pkg::ACT_HIDE, 12'd0, 12'd0, 4'd3, 3'd1, 32'h0, 1'b1);
    wait_idle();

    program_regs(640, 480, 2560, 4, $urandom, $urandom);
    random_phase(50);
    wait_idle();
    program_regs(1, 1, 1, 3, 32'hFFFF_FFFF, 32'h0);
    random_phase(50);
    wait_idle();
    program_regs(4096, 4096, 16384, 4, $urandom, $urandom);
    random_phase(50);
    wait_idle();
    program_regs(8191, 8191, 32767, 7, $urandom, $urandom);
    random_phase(50);
    wait_idle();
    program_regs(0, 0, 0, 0, 32'h0, 32'hFFFF_FFFF);
    random_phase(50);
    wait_idle();
    program_regs($urandom_range(1, 4096), $urandom_range(1, 4096),
                 $urandom_range(1, 16384), $urandom_range(3, 4), $urandom, $urandom);
    random_phase(50);
    wait_idle();
    program_regs($urandom_range(1, 32), $urandom_range(1, 32),
                 $urandom_range(1, 16384), 3, $urandom, $urandom);
    random_phase(50);
    wait_idle();

    // Closing phase at full rate
    steady = 1'b1;
    program_regs($urandom_range(1, 4096), $urandom_range(1, 4096),
                 $urandom_range(1, 16384), $urandom_range(3, 4), $urandom, $urandom);
    random_phase(50);
    wait_idle();

    if (mismatches == 0) begin
      $display("** cursor_sprite_save_under_core: PASSED **");
    end else begin
      $display("** cursor_sprite_save_under_core: FAILED **");
    end
    $finish;
  end

endmodule
